FILE: sv/sfd_pkg.sv
// ============================================================================
// Sonar frame deframer package
// Types and constants shared by the sonar frame deframer.
// ============================================================================
package sfd_pkg;

  // Parser state.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_HEADER = 2'd1,
    ST_DATA   = 2'd2
  } parse_state_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_NO_LF    = 2'd2,
    KIND_TOOSHORT = 2'd3
  } kind_e;

  localparam int unsigned PosWidth = 17;

  typedef logic [PosWidth-1:0] pos_t;

  // Framing bytes.
  localparam logic [7:0] StartByte = 8'h40;
  localparam logic [7:0] LineFeed  = 8'h0A;

  // Byte positions within a frame; the start byte sits at position two.
  localparam pos_t StartPos   = 17'd2;
  localparam pos_t LenLoPos   = 17'd7;
  localparam pos_t LenHiPos   = 17'd8;
  localparam pos_t TxPos      = 17'd9;
  localparam pos_t RxPos      = 17'd10;
  localparam pos_t CountPos   = 17'd11;
  localparam pos_t TypePos    = 17'd12;
  localparam pos_t PayloadPos = 17'd13;
  localparam pos_t EndOffset  = 17'd7;

  // Shortest length that lets a frame end after the type byte.
  localparam logic [15:0] MinLength = 16'd6;

endpackage

FILE: sv/sonar_frame_deframer.sv
// ============================================================================
// Sonar frame deframer
// Byte-serial parser for length-prefixed sonar frames: finds the start byte,
// captures the binary header, forwards payload bytes with their index and
// checks the closing line feed; a length too short to end is reported.
// ============================================================================
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o | rx_byte_i
//  out     | out_valid_o/ out_ready_i| kind_o, data_byte_o, payload_index_o,
//          |                         | msg_type_o, tx_node_o, rx_node_o,
//          |                         | seq_count_o, frame_length_o
//
// One item is taken per cycle while the output register is free; a result
// appears in the output register in the cycle after its item is accepted.
// The single output register sets the rate: a new item is accepted whenever
// that register is empty or being emptied in the same cycle.
// Reset returns the parser to idle with all captured header fields at zero.
// A stalled result holds the input side until it is taken.
module sonar_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  msg_type_o,
  output logic [7:0]  tx_node_o,
  output logic [7:0]  rx_node_o,
  output logic [7:0]  seq_count_o,
  output logic [15:0] frame_length_o
);
  import sfd_pkg::*;

  parse_state_e state_q, state_d;
  pos_t         pos_q, pos_d;
  logic [15:0]  len_q, len_d;
  logic [7:0]   tx_q, tx_d;
  logic [7:0]   rx_q, rx_d;
  logic [7:0]   count_q, count_d;
  logic [7:0]   type_q, type_d;

  logic         out_valid_q;
  logic [1:0]   kind_q, kind_d;
  logic [7:0]   data_q;
  logic [15:0]  index_q, index_d;
  logic [7:0]   otype_q, otype_d;
  logic [7:0]   otx_q, otx_d;
  logic [7:0]   orx_q, orx_d;
  logic [7:0]   ocount_q, ocount_d;
  logic [15:0]  olen_q, olen_d;

  logic         accept;
  logic         emit;
  logic         clear;
  logic         short_len;
  logic         at_end;
  pos_t         pos_inc;
  pos_t         end_pos;
  pos_t         index_full;

  // The output register is free when empty or being drained this cycle.
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign pos_inc    = pos_q + 17'd1;
  assign end_pos    = {1'b0, len_q} + EndOffset;
  assign at_end     = (pos_inc >= end_pos);
  assign short_len  = (len_q < MinLength);
  assign index_full = pos_inc - PayloadPos;

  // Next parser state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_HEADER: begin
        if (pos_inc == TypePos) begin
          state_d = short_len ? ST_IDLE : ST_DATA;
        end else if (pos_inc > TypePos) begin
          state_d = ST_IDLE;
        end
      end
      ST_DATA: begin
        if (at_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = (rx_byte_i == StartByte) ? ST_HEADER : ST_IDLE;
      end
    endcase
  end

  // Header capture, position count and result formation.
  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    count_d  = count_q;
    type_d   = type_q;
    emit     = 1'b0;
    clear    = 1'b0;
    kind_d   = KIND_PAYLOAD;
    index_d  = 16'd0;
    otype_d  = type_q;
    unique case (state_q)
      ST_HEADER: begin
        pos_d = pos_inc;
        case (pos_inc)
          LenLoPos: len_d   = {8'd0, rx_byte_i};
          LenHiPos: len_d   = {rx_byte_i, len_q[7:0]};
          TxPos:    tx_d    = rx_byte_i;
          RxPos:    rx_d    = rx_byte_i;
          CountPos: count_d = rx_byte_i;
          TypePos: begin
            type_d  = rx_byte_i;
            otype_d = rx_byte_i;
            if (short_len) begin
              emit   = 1'b1;
              clear  = 1'b1;
              kind_d = KIND_TOOSHORT;
            end
          end
          default: begin
            if (pos_inc > TypePos) begin
              clear = 1'b1;
            end
          end
        endcase
      end
      ST_DATA: begin
        pos_d = pos_inc;
        emit  = 1'b1;
        if (at_end) begin
          clear  = 1'b1;
          kind_d = (rx_byte_i == LineFeed) ? KIND_GOOD : KIND_NO_LF;
        end else begin
          index_d = index_full[15:0];
        end
      end
      default: begin
        clear = 1'b1;
        if (rx_byte_i == StartByte) begin
          pos_d = StartPos;
        end
      end
    endcase
    // Results carry the header as it stood before any return to idle.
    otx_d    = tx_q;
    orx_d    = rx_q;
    ocount_d = count_q;
    olen_d   = len_q;
    if (clear) begin
      if (state_q == ST_HEADER || state_q == ST_DATA) begin
        pos_d = '0;
      end
      len_d   = 16'd0;
      tx_d    = 8'd0;
      rx_d    = 8'd0;
      count_d = 8'd0;
      type_d  = 8'd0;
    end
  end

  // Parser registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      len_q   <= 16'd0;
      tx_q    <= 8'd0;
      rx_q    <= 8'd0;
      count_q <= 8'd0;
      type_q  <= 8'd0;
    end else if (accept) begin
      state_q <= state_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      count_q <= count_d;
      type_q  <= type_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q   <= kind_d;
      data_q   <= rx_byte_i;
      index_q  <= index_d;
      otype_q  <= otype_d;
      otx_q    <= otx_d;
      orx_q    <= orx_d;
      ocount_q <= ocount_d;
      olen_q   <= olen_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = data_q;
  assign payload_index_o = index_q;
  assign msg_type_o      = otype_q;
  assign tx_node_o       = otx_q;
  assign rx_node_o       = orx_q;
  assign seq_count_o     = ocount_q;
  assign frame_length_o  = olen_q;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// Sonar frame deframer testbench
// Sends framed byte streams, line noise and broken frames into the deframer.
// Every accepted byte goes through a parser model kept here, and each result
// from the block is checked field by field against the oldest prediction.
// Both channels idle at random outside the no-idle phase. One long receiver hold-off backs the block
// up, and the sender pauses between phases until every result is in.
// ============================================================================
module tb_top;
  import sfd_pkg::*;

  // Result of one parsed byte, as the block should report it.
  typedef struct {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [7:0]  msg_type;
    logic [7:0]  tx_node;
    logic [7:0]  rx_node;
    logic [7:0]  seq_count;
    logic [15:0] length;
  } frame_event_t;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned LongHoldAt = 120;
  localparam int unsigned LongHoldCycles = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [15:0] payload_index_o;
  logic [7:0]  msg_type_o;
  logic [7:0]  tx_node_o;
  logic [7:0]  rx_node_o;
  logic [7:0]  seq_count_o;
  logic [15:0] frame_length_o;

  // Bytes waiting to be offered, and results waiting to be seen.
  logic [7:0]   rx_bytes_q [$];
  frame_event_t frame_events_q [$];

  // Parser model state.
  parse_state_e pr_state;
  pos_t         pr_pos;
  logic [15:0]  pr_len;
  logic [7:0]   pr_tx;
  logic [7:0]   pr_rx;
  logic [7:0]   pr_seq;
  logic [7:0]   pr_type;

  logic         idle_enable = 1'b1;
  int unsigned  gap_left = 0;
  int unsigned  hold_left = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  error_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  results_checked = 0;
  int unsigned  payload_seen = 0;
  int unsigned  good_seen = 0;
  int unsigned  no_lf_seen = 0;
  int unsigned  short_seen = 0;
  frame_event_t want_ev;

  // Two noise bytes, a frame of length six with the start byte as transmit
  // node, then a frame whose length is too short to end.
  logic [7:0] directed_bytes [25] = '{
    8'hFF, 8'h00,
    StartByte, "0", "0", "0", "6", 8'h06, 8'h00, StartByte, 8'hFF, 8'h00, 8'h5A,
    LineFeed,
    StartByte, "F", "F", "F", "F", 8'h05, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hA5
  };

  string hex_digits = "0123456789ABCDEF";

  sonar_frame_deframer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .payload_index_o (payload_index_o),
    .msg_type_o      (msg_type_o),
    .tx_node_o       (tx_node_o),
    .rx_node_o       (rx_node_o),
    .seq_count_o     (seq_count_o),
    .frame_length_o  (frame_length_o)
  );

  // Clock, 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Append one byte to the stream waiting to be offered.
  task automatic queue_byte(input logic [7:0] b);
    rx_bytes_q.insert(rx_bytes_q.size(), b);
  endtask

  // Return the parser model to idle with every captured field cleared.
  function automatic void clear_parser();
    pr_state = ST_IDLE;
    pr_pos   = '0;
    pr_len   = '0;
    pr_tx    = '0;
    pr_rx    = '0;
    pr_seq   = '0;
    pr_type  = '0;
  endfunction

  // Build a result from the byte just taken and the captured header.
  function automatic frame_event_t form_event(kind_e kind, logic [7:0] data,
                                              logic [15:0] index);
    frame_event_t ev;
    ev.kind      = kind;
    ev.data      = data;
    ev.index     = index;
    ev.msg_type  = pr_type;
    ev.tx_node   = pr_tx;
    ev.rx_node   = pr_rx;
    ev.seq_count = pr_seq;
    ev.length    = pr_len;
    return ev;
  endfunction

  // Advance the parser model by one byte and queue any result it causes.
  function automatic void parse_rx_byte(logic [7:0] b);
    pos_t  end_pos;
    kind_e end_kind;
    case (pr_state)
      ST_HEADER: begin
        pr_pos = pr_pos + 17'd1;
        case (pr_pos)
          LenLoPos: pr_len = {8'h00, b};
          LenHiPos: pr_len[15:8] = b;
          TxPos:    pr_tx = b;
          RxPos:    pr_rx = b;
          CountPos: pr_seq = b;
          TypePos: begin
            pr_type = b;
            if (pr_len < MinLength) begin
              frame_events_q.insert(frame_events_q.size(),
                                    form_event(KIND_TOOSHORT, b, 16'd0));
              clear_parser();
            end else begin
              pr_state = ST_DATA;
            end
          end
          default: begin
            // The hex length characters are skipped.
            if (pr_pos > TypePos) clear_parser();
          end
        endcase
      end
      ST_DATA: begin
        pr_pos  = pr_pos + 17'd1;
        end_pos = {1'b0, pr_len} + EndOffset;
        if (pr_pos >= end_pos) begin
          if (b == LineFeed) begin
            end_kind = KIND_GOOD;
          end else begin
            end_kind = KIND_NO_LF;
          end
          frame_events_q.insert(frame_events_q.size(), form_event(end_kind, b, 16'd0));
          clear_parser();
        end else begin
          frame_events_q.insert(frame_events_q.size(),
                                form_event(KIND_PAYLOAD, b, 16'(pr_pos - PayloadPos)));
        end
      end
      default: begin
        // Idle: only the start byte opens a frame.
        if (b == StartByte) begin
          clear_parser();
          pr_state = ST_HEADER;
          pr_pos   = StartPos;
        end else begin
          pr_state = ST_IDLE;
        end
      end
    endcase
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (!idle_enable || pick < 90) return 0;
    if (pick < 98) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 30) $display("tb_top: mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h expected %h",
                                results_checked, name, got, want));
  endtask

  // Queue one frame: start byte, hex length and binary header, then payload
  // and the closing byte if the length reaches the minimum.
  task automatic queue_frame(input logic [15:0] len, input logic [7:0] tail);
    int unsigned n;
    queue_byte(StartByte);
    for (n = 0; n < 4; n++) queue_byte(hex_digits[$urandom_range(0, 15)]);
    queue_byte(len[7:0]);
    queue_byte(len[15:8]);
    for (n = 0; n < 4; n++) queue_byte(8'($urandom));
    if (len >= MinLength) begin
      for (n = 0; n < len - MinLength; n++) queue_byte(8'($urandom));
      queue_byte(tail);
    end
  endtask

  // Mostly well-formed frames with random content, plus line noise between
  // frames and frames cut short by garbage.
  task automatic queue_random_traffic(input int unsigned n_items);
    int unsigned made;
    int unsigned pick;
    int unsigned before_sz;
    int unsigned n;
    logic [15:0] len;
    logic [7:0]  tail;
    logic [7:0]  noise;
    made = 0;
    while (made < n_items) begin
      pick      = $urandom_range(0, 99);
      before_sz = rx_bytes_q.size();
      if (pick < 75) begin
        n = $urandom_range(0, 99);
        if (n < 10)      len = 16'($urandom_range(0, 5));
        else if (n < 13) len = 16'($urandom_range(256, 300));
        else             len = 16'($urandom_range(6, 24));
        tail = ($urandom_range(0, 4) == 0) ? 8'($urandom) : LineFeed;
        queue_frame(len, tail);
        made += rx_bytes_q.size() - before_sz;
      end else if (pick < 88) begin
        // Noise while idle is dropped and does not count.
        for (n = $urandom_range(1, 4); n > 0; n--) begin
          noise = 8'($urandom);
          queue_byte((noise == StartByte) ? 8'h41 : noise);
        end
      end else begin
        queue_byte(StartByte);
        for (n = $urandom_range(1, 12); n > 0; n--) queue_byte(8'($urandom));
        made += rx_bytes_q.size() - before_sz;
      end
    end
  endtask

  // Hold the sender back until every byte is taken and every result is in.
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (rx_bytes_q.size() != 0 || in_valid_i || frame_events_q.size() != 0);
  endtask

  // Byte driver: predicts on each accepted item, then offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        parse_rx_byte(rx_byte_i);
        bytes_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_bytes_q.pop_front();
          gap_left   = draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result and drives ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (frame_events_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, kind %h data %h",
                                    kind_o, data_byte_o));
        end else begin
          want_ev = frame_events_q.pop_front();
          check_field("kind", 16'(kind_o), 16'(want_ev.kind));
          check_field("data_byte", 16'(data_byte_o), 16'(want_ev.data));
          check_field("payload_index", payload_index_o, want_ev.index);
          check_field("msg_type", 16'(msg_type_o), 16'(want_ev.msg_type));
          check_field("tx_node", 16'(tx_node_o), 16'(want_ev.tx_node));
          check_field("rx_node", 16'(rx_node_o), 16'(want_ev.rx_node));
          check_field("seq_count", 16'(seq_count_o), 16'(want_ev.seq_count));
          check_field("frame_length", frame_length_o, want_ev.length);
          case (want_ev.kind)
            KIND_PAYLOAD: payload_seen++;
            KIND_GOOD:    good_seen++;
            KIND_NO_LF:   no_lf_seen++;
            default:      short_seen++;
          endcase
        end
        results_checked++;
        // One long hold-off so that the block backs up onto its input.
        if (results_checked == LongHoldAt) hold_left = LongHoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        hold_left   = draw_gap();
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QuietLimit) begin
        $display("tb_top: no handshake for %0d cycles, %0d results outstanding",
                 QuietLimit, frame_events_q.size());
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    clear_parser();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed bytes: field extremes, length of six, too-short length.
    foreach (directed_bytes[i]) queue_byte(directed_bytes[i]);
    wait_for_drain();

    // Random traffic with idling on both sides.
    queue_random_traffic(350);
    wait_for_drain();

    // Random traffic with no idling at all.
    idle_enable <= 1'b0;
    queue_random_traffic(350);
    wait_for_drain();
    idle_enable <= 1'b1;

    repeat (20) @(posedge clk_i);
    if (frame_events_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", frame_events_q.size()));

    $display("tb_top: %0d bytes parsed, %0d results compared", bytes_sent, results_checked);
    $display("tb_top: %0d payload bytes, %0d good frames, %0d missing line feed, %0d too short",
             payload_seen, good_seen, no_lf_seen, short_seen);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
